// ----- hw/rtl/sdf_pkg.sv -----
// Package for the subrecord stream deframer.
// Holds the result kinds, error codes, header constants and the result record type.
// No dependencies.
`timescale 1ns / 1ps

package sdf_pkg;

	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [2:0] ERR_TRUNC_HEADER  = 3'd0;
	localparam logic [2:0] ERR_DUP_EXT       = 3'd1;
	localparam logic [2:0] ERR_INVALID_EXT   = 3'd2;
	localparam logic [2:0] ERR_TRUNC_PAYLOAD = 3'd3;
	localparam logic [2:0] ERR_DANGLING_EXT  = 3'd4;

	// "XXXX" marks a header that carries the extended length of the next record.
	localparam logic [31:0] EXT_SIGNATURE = 32'h5858_5858;
	localparam logic [15:0] EXT_SHORT_LENGTH = 16'd4;
	localparam logic [2:0]  HEADER_BYTES = 3'd6;
	localparam logic [2:0]  SIGNATURE_BYTES = 3'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] record_signature;
		logic [31:0] payload_length;
		logic [7:0]  payload_byte;
		logic [2:0]  error_code;
		logic [31:0] position;
		logic        last;
	} result_t;

	function automatic result_t make_result(
		input logic [1:0]  kind,
		input logic [31:0] sig,
		input logic [31:0] len,
		input logic [7:0]  data,
		input logic [2:0]  code,
		input logic [31:0] pos
	);
		result_t r;
		r.kind             = kind;
		r.record_signature = sig;
		r.payload_length   = len;
		r.payload_byte     = data;
		r.error_code       = code;
		r.position         = pos;
		r.last             = 1'b0;
		return r;
	endfunction

endpackage

// ----- hw/rtl/sdf_in_if.sv -----
// Input channel of the subrecord stream deframer: a body byte, an end marker or both per beat.
// No dependencies.
`timescale 1ns / 1ps

interface sdf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_body;

	modport source (output valid, data_byte, byte_valid, end_of_body, input ready);
	modport sink (input valid, data_byte, byte_valid, end_of_body, output ready);
endinterface

// ----- hw/rtl/sdf_out_if.sv -----
// Result channel of the subrecord stream deframer: one result record per beat.
// No dependencies.
`timescale 1ns / 1ps

interface sdf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] record_signature;
	logic [31:0] payload_length;
	logic [7:0]  payload_byte;
	logic [2:0]  error_code;
	logic [31:0] position;
	logic        last;

	modport source (output valid, kind, record_signature, payload_length, payload_byte,
		error_code, position, last, input ready);
	modport sink (input valid, kind, record_signature, payload_length, payload_byte,
		error_code, position, last, output ready);
endinterface

// ----- hw/rtl/subrecord_stream_deframer.sv -----
// Top level of the subrecord stream deframer.
// Depends on sdf_pkg, sdf_in_if and sdf_out_if.
`timescale 1ns / 1ps

// Splits a byte stream into records of a 4-byte signature, a 16-bit little-endian
// length and the payload; an "XXXX" header supplies a 32-bit length for the next
// record. Each accepted beat is decoded in the cycle it is taken and gives zero,
// one or two results, which go into a four-entry result queue. The input is ready
// whenever the queue has room for two results, so with the result side ready the
// block takes one beat per cycle until beats that yield two results (a record start
// or payload byte together with its end or error) fill the queue, since the queue
// drains one result per cycle. Results are registered in the queue before output.
module subrecord_stream_deframer #(
	parameter int OFFSET_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	sdf_in_if.sink     body,
	sdf_out_if.source  rec
);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_EXT,
		PH_PAYLOAD,
		PH_DROP
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [2:0]              hdr_cnt_q, hdr_cnt_d;
	logic [31:0]             sig_q, sig_d;
	logic [15:0]             short_len_q, short_len_d;
	logic                    ext_pend_q, ext_pend_d;
	logic [31:0]             ext_val_q, ext_val_d;
	logic [1:0]              ext_cnt_q, ext_cnt_d;
	logic [31:0]             remain_q, remain_d;
	logic [OFFSET_WIDTH-1:0] body_pos_q, body_pos_d;
	logic [OFFSET_WIDTH-1:0] hdr_start_q, hdr_start_d;

	sdf_pkg::result_t res0, res1;
	logic [1:0]       res_n;

	sdf_pkg::result_t  queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic in_fire, out_fire;

	assign body.ready = (count_q <= QCNT_W'(QDEPTH - 2));
	assign in_fire    = body.valid & body.ready;
	assign out_fire   = rec.valid & rec.ready;

	always_comb begin
		logic [2:0]       hc;
		logic [31:0]      len;
		sdf_pkg::result_t r;
		logic             have;

		phase_d     = phase_q;
		hdr_cnt_d   = hdr_cnt_q;
		sig_d       = sig_q;
		short_len_d = short_len_q;
		ext_pend_d  = ext_pend_q;
		ext_val_d   = ext_val_q;
		ext_cnt_d   = ext_cnt_q;
		remain_d    = remain_q;
		body_pos_d  = body_pos_q;
		hdr_start_d = hdr_start_q;
		res0        = '0;
		res1        = '0;
		res_n       = 2'd0;
		hc          = hdr_cnt_q;
		len         = '0;
		r           = '0;
		have        = 1'b0;

		// Result of the byte part of the beat, at most one.
		if (body.byte_valid) begin
			case (phase_q)
				PH_HEADER: begin
					if (hc == 3'd0) begin
						hdr_start_d = body_pos_q;
					end
					if (hc < sdf_pkg::SIGNATURE_BYTES) begin
						sig_d = {sig_q[23:0], body.data_byte};
					end else begin
						short_len_d = {body.data_byte, short_len_q[15:8]};
					end
					hdr_cnt_d = 3'(hc + 3'd1);
					if (hdr_cnt_d == sdf_pkg::HEADER_BYTES) begin
						hdr_cnt_d = 3'd0;
						if (sig_d == sdf_pkg::EXT_SIGNATURE) begin
							if (ext_pend_q) begin
								r = sdf_pkg::make_result(sdf_pkg::KIND_ERROR, '0, '0, '0,
									sdf_pkg::ERR_DUP_EXT, 32'(hdr_start_d));
								have = 1'b1;
								phase_d = PH_DROP;
							end else if (short_len_d != sdf_pkg::EXT_SHORT_LENGTH) begin
								r = sdf_pkg::make_result(sdf_pkg::KIND_ERROR, '0, '0, '0,
									sdf_pkg::ERR_INVALID_EXT, 32'(hdr_start_d));
								have = 1'b1;
								phase_d = PH_DROP;
							end else begin
								phase_d   = PH_EXT;
								ext_cnt_d = 2'd0;
								ext_val_d = '0;
							end
						end else begin
							len = ext_pend_q ? ext_val_q : {16'd0, short_len_d};
							ext_pend_d = 1'b0;
							r = sdf_pkg::make_result(sdf_pkg::KIND_START, sig_d, len, '0,
								'0, 32'(hdr_start_d));
							have = 1'b1;
							remain_d = len;
							phase_d = (len != 32'd0) ? PH_PAYLOAD : PH_HEADER;
						end
					end
				end
				PH_EXT: begin
					ext_val_d = {body.data_byte, ext_val_q[31:8]};
					if (ext_cnt_q == 2'd3) begin
						ext_cnt_d  = 2'd0;
						ext_pend_d = 1'b1;
						phase_d    = PH_HEADER;
					end else begin
						ext_cnt_d = 2'(ext_cnt_q + 2'd1);
					end
				end
				PH_PAYLOAD: begin
					r = sdf_pkg::make_result(sdf_pkg::KIND_PAYLOAD, '0, '0, body.data_byte,
						'0, '0);
					have = 1'b1;
					remain_d = 32'(remain_q - 32'd1);
					if (remain_d == 32'd0) begin
						phase_d = PH_HEADER;
					end
				end
				default: begin
				end
			endcase
			body_pos_d = OFFSET_WIDTH'(body_pos_q + OFFSET_WIDTH'(1));
		end

		if (have) begin
			res0  = r;
			res_n = 2'd1;
		end

		if (body.end_of_body) begin
			have = 1'b0;
			case (phase_d)
				PH_HEADER: begin
					have = 1'b1;
					if (hdr_cnt_d != 3'd0) begin
						r = sdf_pkg::make_result(sdf_pkg::KIND_ERROR, '0, '0, '0,
							sdf_pkg::ERR_TRUNC_HEADER, 32'(hdr_start_d));
					end else if (ext_pend_d) begin
						r = sdf_pkg::make_result(sdf_pkg::KIND_ERROR, '0, '0, '0,
							sdf_pkg::ERR_DANGLING_EXT, 32'(body_pos_d));
					end else begin
						r = sdf_pkg::make_result(sdf_pkg::KIND_END, '0, '0, '0, '0,
							32'(body_pos_d));
					end
				end
				PH_EXT, PH_PAYLOAD: begin
					have = 1'b1;
					r = sdf_pkg::make_result(sdf_pkg::KIND_ERROR, '0, '0, '0,
						sdf_pkg::ERR_TRUNC_PAYLOAD, 32'(hdr_start_d));
				end
				default: begin
				end
			endcase
			if (have) begin
				if (res_n == 2'd0) begin
					res0 = r;
				end else begin
					res1 = r;
				end
				res_n = 2'(res_n + 2'd1);
			end
			// Every end readies the next body.
			phase_d     = PH_HEADER;
			hdr_cnt_d   = '0;
			sig_d       = '0;
			short_len_d = '0;
			ext_pend_d  = 1'b0;
			ext_val_d   = '0;
			ext_cnt_d   = '0;
			remain_d    = '0;
			body_pos_d  = '0;
			hdr_start_d = '0;
		end

		if (res_n == 2'd2) begin
			res1.last = 1'b1;
		end else if (res_n == 2'd1) begin
			res0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_cnt_q   <= '0;
			sig_q       <= '0;
			short_len_q <= '0;
			ext_pend_q  <= 1'b0;
			ext_val_q   <= '0;
			ext_cnt_q   <= '0;
			remain_q    <= '0;
			body_pos_q  <= '0;
			hdr_start_q <= '0;
		end else if (in_fire) begin
			phase_q     <= phase_d;
			hdr_cnt_q   <= hdr_cnt_d;
			sig_q       <= sig_d;
			short_len_q <= short_len_d;
			ext_pend_q  <= ext_pend_d;
			ext_val_q   <= ext_val_d;
			ext_cnt_q   <= ext_cnt_d;
			remain_q    <= remain_d;
			body_pos_q  <= body_pos_d;
			hdr_start_q <= hdr_start_d;
		end
	end

	// Result queue: up to two writes and one read per cycle.
	always_ff @(posedge clk) begin
		if (in_fire && res_n != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
			if (res_n == 2'd2) begin
				queue_q[QPTR_W'(wr_ptr_q + QPTR_W'(1))] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_fire) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + QPTR_W'(res_n));
			end
			if (out_fire) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + QPTR_W'(1));
			end
			count_q <= QCNT_W'(count_q + (in_fire ? QCNT_W'(res_n) : QCNT_W'(0))
				- (out_fire ? QCNT_W'(1) : QCNT_W'(0)));
		end
	end

	assign rec.valid            = (count_q != '0);
	assign rec.kind             = queue_q[rd_ptr_q].kind;
	assign rec.record_signature = queue_q[rd_ptr_q].record_signature;
	assign rec.payload_length   = queue_q[rd_ptr_q].payload_length;
	assign rec.payload_byte     = queue_q[rd_ptr_q].payload_byte;
	assign rec.error_code       = queue_q[rd_ptr_q].error_code;
	assign rec.position         = queue_q[rd_ptr_q].position;
	assign rec.last             = queue_q[rd_ptr_q].last;

endmodule

// ----- hw/rtl/sdf_checker.sv -----
// Port-level checks for the subrecord stream deframer, bound to the top level.
// Depends on sdf_pkg and subrecord_stream_deframer.
`timescale 1ns / 1ps

module sdf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [31:0] record_signature,
	input logic [31:0] payload_length,
	input logic [7:0]  payload_byte,
	input logic [2:0]  error_code,
	input logic [31:0] position,
	input logic        last
);

	// A stalled result beat keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(position)
			&& $stable(payload_byte) && $stable(last))
		else $error("stalled result beat changed");

	// An end or an error is always the final result of its input beat.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == sdf_pkg::KIND_END || kind == sdf_pkg::KIND_ERROR) |-> last)
		else $error("end or error result without last");

	// Payload byte beats carry nothing besides the byte.
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == sdf_pkg::KIND_PAYLOAD |-> record_signature == 32'd0
			&& payload_length == 32'd0 && error_code == 3'd0 && position == 32'd0)
		else $error("payload byte beat with stray fields");

	// Error codes only appear on error beats, and stay within the defined set.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == sdf_pkg::KIND_ERROR) ? (error_code <= sdf_pkg::ERR_DANGLING_EXT)
			: (error_code == 3'd0))
		else $error("error code out of place");

endmodule

bind subrecord_stream_deframer sdf_checker u_sdf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (rec.valid),
	.out_ready        (rec.ready),
	.kind             (rec.kind),
	.record_signature (rec.record_signature),
	.payload_length   (rec.payload_length),
	.payload_byte     (rec.payload_byte),
	.error_code       (rec.error_code),
	.position         (rec.position),
	.last             (rec.last)
);
